@@ sv/hpq_pkg.sv @@
// Package for the heap priority queue: sizes, entry and channel types, request codes.
`default_nettype none
package hpq_pkg;

    localparam int HEAP_DEPTH = 64;
    localparam int IDX_W      = $clog2(HEAP_DEPTH);
    localparam int CNT_W      = $clog2(HEAP_DEPTH + 1);
    localparam int CH_W       = IDX_W + 2;

    localparam logic REQ_ENQ = 1'b0;
    localparam logic REQ_DEQ = 1'b1;

    typedef struct packed {
        logic [7:0]  prio;
        logic [15:0] job;
        logic [15:0] pages;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic        req_type;
        logic [7:0]  priority_req;
        logic [15:0] job_number;
        logic [15:0] page_count;
    } t_req;

    typedef struct packed {
        logic             top_valid;
        logic [7:0]       top_priority;
        logic [15:0]      top_job_number;
        logic [15:0]      top_page_count;
        logic [CNT_W-1:0] entry_count;
        logic             dropped;
    } t_rsp;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        t_entry           wdata;
        logic             re;
        logic [IDX_W-1:0] raddr;
    } t_ram_cmd;

endpackage
`default_nettype wire

@@ sv/hpq_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module hpq_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

@@ sv/hpq_sift.sv @@
// Sift engine: walks the heap in memory one level at a time, holding the moving entry.
`default_nettype none
module hpq_sift
    import hpq_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_start,
    input  wire t_req     i_req,
    output logic          o_idle,
    output logic          o_done,
    input  wire logic     i_take,
    output t_rsp          o_rsp,
    output t_ram_cmd      o_ram,
    input  wire t_entry   i_rdata
);

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_UP_CHK  = 4'd1;
    localparam logic [3:0] ST_UP_CMP  = 4'd2;
    localparam logic [3:0] ST_DN_LAST = 4'd3;
    localparam logic [3:0] ST_DN_CHK  = 4'd4;
    localparam logic [3:0] ST_DN_L    = 4'd5;
    localparam logic [3:0] ST_DN_R    = 4'd6;
    localparam logic [3:0] ST_FIN     = 4'd7;

    logic [3:0]       r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [IDX_W-1:0] r_hole, n_hole;
    t_entry           r_mov, n_mov;
    t_entry           r_left, n_left;
    t_entry           r_top, n_top;
    logic             r_drop, n_drop;

    logic [CH_W-1:0]  w_lchild, w_rchild, w_cnt_ext;
    logic [IDX_W-1:0] w_parent;
    logic             w_full, w_left_take;
    logic [7:0]       w_best_prio;
    t_entry           w_new;

    assign w_lchild    = {1'b0, r_hole, 1'b1};
    assign w_rchild    = w_lchild + CH_W'(1);
    assign w_cnt_ext   = CH_W'(r_cnt);
    assign w_parent    = (r_hole - IDX_W'(1)) >> 1;
    assign w_full      = (r_cnt == CNT_W'(HEAP_DEPTH));
    assign w_left_take = (r_left.prio > r_mov.prio);
    assign w_best_prio = w_left_take ? r_left.prio : r_mov.prio;
    assign w_new       = '{prio: i_req.priority_req, job: i_req.job_number,
                           pages: i_req.page_count};

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_hole  = r_hole;
        n_mov   = r_mov;
        n_left  = r_left;
        n_top   = r_top;
        n_drop  = r_drop;
        o_ram   = '{we: 1'b0, waddr: r_hole, wdata: r_mov, re: 1'b0, raddr: w_parent};

        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_drop = 1'b0;
                    if (i_req.req_type == REQ_ENQ) begin
                        if (w_full) begin
                            n_drop  = 1'b1;
                            n_state = ST_FIN;
                        end else begin
                            n_mov   = w_new;
                            n_hole  = r_cnt[IDX_W-1:0];
                            n_cnt   = r_cnt + CNT_W'(1);
                            n_state = ST_UP_CHK;
                        end
                    end else if (r_cnt == '0) begin
                        n_state = ST_FIN;
                    end else begin
                        n_cnt = r_cnt - CNT_W'(1);
                        if (r_cnt == CNT_W'(1)) begin
                            n_state = ST_FIN;
                        end else begin
                            // fetch the last entry; it becomes the mover from the root
                            o_ram.re    = 1'b1;
                            o_ram.raddr = n_cnt[IDX_W-1:0];
                            n_state     = ST_DN_LAST;
                        end
                    end
                end
            end
            ST_UP_CHK: begin
                if (r_hole == '0) begin
                    o_ram.we = 1'b1;
                    n_state  = ST_FIN;
                end else begin
                    o_ram.re = 1'b1;
                    n_state  = ST_UP_CMP;
                end
            end
            ST_UP_CMP: begin
                if (i_rdata.prio < r_mov.prio) begin
                    o_ram.we    = 1'b1;
                    o_ram.wdata = i_rdata;
                    n_hole      = w_parent;
                    n_state     = ST_UP_CHK;
                end else begin
                    o_ram.we = 1'b1;
                    n_state  = ST_FIN;
                end
            end
            ST_DN_LAST: begin
                n_mov   = i_rdata;
                n_hole  = '0;
                n_state = ST_DN_CHK;
            end
            ST_DN_CHK: begin
                if (w_lchild >= w_cnt_ext) begin
                    o_ram.we = 1'b1;
                    n_state  = ST_FIN;
                end else begin
                    o_ram.re    = 1'b1;
                    o_ram.raddr = w_lchild[IDX_W-1:0];
                    n_state     = ST_DN_L;
                end
            end
            ST_DN_L: begin
                n_left = i_rdata;
                if (w_rchild < w_cnt_ext) begin
                    o_ram.re    = 1'b1;
                    o_ram.raddr = w_rchild[IDX_W-1:0];
                    n_state     = ST_DN_R;
                end else if (i_rdata.prio > r_mov.prio) begin
                    o_ram.we    = 1'b1;
                    o_ram.wdata = i_rdata;
                    n_hole      = w_lchild[IDX_W-1:0];
                    n_state     = ST_DN_CHK;
                end else begin
                    o_ram.we = 1'b1;
                    n_state  = ST_FIN;
                end
            end
            ST_DN_R: begin
                // right wins only when strictly above the left/mover winner
                if (i_rdata.prio > w_best_prio) begin
                    o_ram.we    = 1'b1;
                    o_ram.wdata = i_rdata;
                    n_hole      = w_rchild[IDX_W-1:0];
                    n_state     = ST_DN_CHK;
                end else if (w_left_take) begin
                    o_ram.we    = 1'b1;
                    o_ram.wdata = r_left;
                    n_hole      = w_lchild[IDX_W-1:0];
                    n_state     = ST_DN_CHK;
                end else begin
                    o_ram.we = 1'b1;
                    n_state  = ST_FIN;
                end
            end
            ST_FIN: begin
                if (i_take) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // shadow the root so the top needs no extra read
        if (o_ram.we && (o_ram.waddr == '0)) begin
            n_top = o_ram.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_drop  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_drop  <= n_drop;
        end
        r_hole <= n_hole;
        r_mov  <= n_mov;
        r_left <= n_left;
        r_top  <= n_top;
    end

    assign o_idle = (r_state == ST_IDLE);
    assign o_done = (r_state == ST_FIN);

    always_comb begin
        o_rsp.top_valid      = (r_cnt != '0);
        o_rsp.top_priority   = o_rsp.top_valid ? r_top.prio  : '0;
        o_rsp.top_job_number = o_rsp.top_valid ? r_top.job   : '0;
        o_rsp.top_page_count = o_rsp.top_valid ? r_top.pages : '0;
        o_rsp.entry_count    = r_cnt;
        o_rsp.dropped        = r_drop;
    end

endmodule
`default_nettype wire

@@ sv/binary_max_heap_priority_queue_unit.sv @@
// Top level of the heap priority queue: input handshake, sift engine, heap RAM, result register.
// Enqueue sifts the new entry up one level at a time; dequeue moves the last entry to the root and
// sifts it down. A refused enqueue, or a dequeue that finds the heap empty or empties it, goes
// straight to the result without touching the RAM.
// Throughput: one item at a time; input is ready again in the cycle after the result loads.
// Reset (i_rst_n, synchronous, active low) empties the queue; the RAM is not cleared.
`default_nettype none
module binary_max_heap_priority_queue_unit
    import hpq_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_req i_in_data,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    output t_rsp      o_out_data
);

    t_ram_cmd w_ram;
    t_entry   w_rdata;
    t_rsp     w_rsp;
    logic     w_idle, w_done, w_take;
    logic     r_out_valid;
    t_rsp     r_out_data;

    // The result register can load when it is empty or its item transfers this cycle.
    assign w_take = !r_out_valid || i_out_ready;

    // Take a new item only while the sift engine is idle.
    assign o_in_ready = w_idle;

    hpq_sift u_sift (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_in_valid && w_idle),
        .i_req   (i_in_data),
        .o_idle  (w_idle),
        .o_done  (w_done),
        .i_take  (w_take),
        .o_rsp   (w_rsp),
        .o_ram   (w_ram),
        .i_rdata (w_rdata)
    );

    hpq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (HEAP_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram.we),
        .i_waddr (w_ram.waddr),
        .i_wdata (w_ram.wdata),
        .i_re    (w_ram.re),
        .i_raddr (w_ram.raddr),
        .o_rdata (w_rdata)
    );

    // Hold the finished result until the consumer takes it; advance on each transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_done && w_take) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (w_done && w_take) begin
            r_out_data <= w_rsp;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule
`default_nettype wire
